### rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int WORD_WIDTH   = 32;
   localparam int MODE_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;

   typedef logic signed [WORD_WIDTH-1:0] deq_word_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } deq_mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } deq_status_type;

   // Operation broadcast to every cell; at most one bit is set, and only for
   // a beat that changes the contents.
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } deq_op_type;

endpackage

### rtl/deq_if.sv
`timescale 1ns / 1ps

interface deq_req_if
   import deq_pkg::*;
   ();
   logic         valid;
   logic         ready;
   deq_mode_type mode;
   deq_word_type push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
   ();
   logic           valid;
   logic           ready;
   deq_word_type   popped_value;
   deq_status_type status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink   (input valid, input popped_value, input status, output ready);
endinterface

### rtl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  deq_op_type   op,
   input  deq_word_type value,
   input  logic         prev_occ,
   input  logic         next_occ,
   input  deq_word_type left_front_word,
   input  deq_word_type right_front_word,
   input  deq_word_type left_rear_word,
   input  deq_word_type right_rear_word,
   output logic         occ,
   output deq_word_type front_word,
   output deq_word_type rear_word
);

   logic         occ_ff, occ_in;
   deq_word_type front_word_ff, front_word_in;
   deq_word_type rear_word_ff, rear_word_in;
   logic         slot;

   // This cell is the first free one, where an append lands.
   assign slot = !occ_ff && prev_occ;

   always_comb begin
      occ_in        = occ_ff;
      front_word_in = front_word_ff;
      rear_word_in  = rear_word_ff;
      if (op.push_front) begin
         front_word_in = left_front_word;
         if (slot) begin
            rear_word_in = value;
         end
         occ_in = occ_ff | prev_occ;
      end else if (op.push_rear) begin
         rear_word_in = left_rear_word;
         if (slot) begin
            front_word_in = value;
         end
         occ_in = occ_ff | prev_occ;
      end else if (op.pop_front) begin
         front_word_in = right_front_word;
         occ_in        = next_occ;
      end else if (op.pop_rear) begin
         rear_word_in = right_rear_word;
         occ_in       = next_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      rear_word_ff  <= rear_word_in;
   end

   assign occ        = occ_ff;
   assign front_word = front_word_ff;
   assign rear_word  = rear_word_ff;

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// A result beat is registered in the cycle after its request beat is accepted.
// Throughput: one request per cycle while result beats are taken; the row of
// cells shifts one place per beat, and a request can enter as a result leaves.
// Reset (synchronous, active high) empties the queue at once; stored words
// are not cleared, since only occupied cells are ever read.

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 128
)
(
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   // The queue lives in a row of DEPTH cells. Each cell holds one bit of a
   // thermometer occupancy code and two words. The front chain keeps the
   // entries in order with the front entry in cell 0; the rear chain keeps
   // the same entries reversed, with the rear entry in cell 0. A push at one
   // end shifts that end's chain right and appends the word at the tail of
   // the other chain; a pop shifts that end's chain left and simply drops
   // the tail of the other chain by shrinking the occupancy. Both ends are
   // therefore always read from cell 0.

   logic [DEPTH-1:0] occ_vec;
   deq_word_type     front_words [DEPTH];
   deq_word_type     rear_words  [DEPTH];

   deq_op_type       op;
   logic             req_accept;
   logic             full;
   logic             empty;

   logic             rsp_valid_ff, rsp_valid_in;
   deq_word_type     popped_value_ff, popped_value_in;
   deq_status_type   status_ff, status_in;

   assign full  = occ_vec[DEPTH-1];
   assign empty = !occ_vec[0];

   // The output register parts the two sides: a request is taken whenever
   // the result slot is free or is being emptied in this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Decode the request beat into the operation for the row and the result.
   always_comb begin
      op              = '0;
      status_in       = STATUS_OK;
      popped_value_in = '0;
      case (req_chan.mode)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               op.push_front = req_accept;
            end
         end
         MODE_PUSH_REAR: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               op.push_rear = req_accept;
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               op.pop_front    = req_accept;
               popped_value_in = front_words[0];
            end
         end
         MODE_POP_REAR: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               op.pop_rear     = req_accept;
               popped_value_in = rear_words[0];
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // The row of cells. Cell 0 takes the pushed word from its left side; the
   // last cell sees an empty neighbor on its right.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic         prev_occ;
      logic         next_occ;
      deq_word_type left_front_word;
      deq_word_type left_rear_word;
      deq_word_type right_front_word;
      deq_word_type right_rear_word;

      if (i == 0) begin : g_first
         assign prev_occ        = 1'b1;
         assign left_front_word = req_chan.push_value;
         assign left_rear_word  = req_chan.push_value;
      end else begin : g_inner_left
         assign prev_occ        = occ_vec[i-1];
         assign left_front_word = front_words[i-1];
         assign left_rear_word  = rear_words[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign next_occ         = 1'b0;
         assign right_front_word = front_words[i];
         assign right_rear_word  = rear_words[i];
      end else begin : g_inner_right
         assign next_occ         = occ_vec[i+1];
         assign right_front_word = front_words[i+1];
         assign right_rear_word  = rear_words[i+1];
      end

      deq_cell u_cell (
         .clock            (clock),
         .reset            (reset),
         .op               (op),
         .value            (req_chan.push_value),
         .prev_occ         (prev_occ),
         .next_occ         (next_occ),
         .left_front_word  (left_front_word),
         .right_front_word (right_front_word),
         .left_rear_word   (left_rear_word),
         .right_rear_word  (right_rear_word),
         .occ              (occ_vec[i]),
         .front_word       (front_words[i]),
         .rear_word        (rear_words[i])
      );
   end

   // Result register: valid is set by an accepted beat and cleared once the
   // result beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         popped_value_ff <= popped_value_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_value_ff;
   assign rsp_chan.status       = status_ff;

   // Occupancy must stay a thermometer code: no occupied cell after a free one.
   assert property (@(posedge clock) disable iff (reset)
      (occ_vec & ~{occ_vec[DEPTH-2:0], 1'b1}) == '0)
      else $error("occupancy is not contiguous from cell 0");

   // Reset leaves the queue empty.
   assert property (@(posedge clock) reset |=> (occ_vec == '0))
      else $error("queue not empty after reset");

   // A refused push must not change the contents.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && full && (req_chan.mode == MODE_PUSH_FRONT ||
                              req_chan.mode == MODE_PUSH_REAR))
      |=> $stable(occ_vec))
      else $error("refused push changed occupancy");

   // A failed beat carries a zero word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_OK) |-> (popped_value_ff == '0))
      else $error("failed beat carries a nonzero word");

   // An accepted pop on an empty queue must report empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && empty && (req_chan.mode == MODE_POP_FRONT ||
                               req_chan.mode == MODE_POP_REAR))
      |=> (status_ff == STATUS_EMPTY))
      else $error("pop on empty queue not reported");

endmodule

### tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 128;

   // Idling phase codes; set_phase gives each phase its idle odds, in percent.
   localparam int PHASE_QUIET_RX = 0;
   localparam int PHASE_QUIET_TX = 1;
   localparam int PHASE_NO_IDLE  = 2;

   // A long receiver hold-off: the block must fill its result path and push
   // back on the request side while the sender keeps offering beats.
   localparam int RSP_HOLD_CYCLES = 200;

   // Cycles without any accepted beat before the run is declared hung. This
   // is well above the hold-off plus the longest likely random stall.
   localparam int WATCHDOG_LIMIT = 2000;

   // Request counts at which the idling phases change and the run stops.
   localparam int PHASE1_ITEMS = 430;
   localparam int PHASE2_ITEMS = 860;
   localparam int TOTAL_ITEMS  = 1300;

   // One expected result beat.
   typedef struct {
      deq_word_type   popped_value;
      deq_status_type status;
   } deq_result_type;

   // Mirror of the deque contents. Each accepted request updates a private
   // copy of the circular store, and the result it must produce is queued
   // until the matching result beat arrives.
   class deque_mirror_type;
      deq_word_type   words [QUEUE_DEPTH];
      int unsigned    front_pos;
      int unsigned    held;
      deq_result_type pending_results[$];
      int             mismatches;

      function new();
         front_pos  = 0;
         held       = 0;
         mismatches = 0;
      endfunction

      function void apply_request(deq_mode_type mode, deq_word_type value);
         deq_result_type outcome;
         int unsigned    slot;
         outcome.popped_value = '0;
         outcome.status       = STATUS_OK;
         if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR) begin
            if (held == QUEUE_DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  front_pos = (front_pos == 0) ? QUEUE_DEPTH - 1 : front_pos - 1;
                  slot = front_pos;
               end else begin
                  slot = (front_pos + held) % QUEUE_DEPTH;
               end
               words[slot] = value;
               held++;
            end
         end else begin
            if (held == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               if (mode == MODE_POP_FRONT) begin
                  slot = front_pos;
                  front_pos = (front_pos + 1) % QUEUE_DEPTH;
               end else begin
                  slot = (front_pos + held - 1) % QUEUE_DEPTH;
               end
               outcome.popped_value = words[slot];
               held--;
            end
         end
         pending_results.push_back(outcome);
      endfunction

      function void check_result(deq_word_type popped_value, deq_status_type status);
         deq_result_type wanted;
         if (pending_results.size() == 0) begin
            $display("%0t ns: result beat with no request outstanding: value %0d status %0d",
                     $time, popped_value, status);
            mismatches++;
            return;
         end
         wanted = pending_results.pop_front();
         if (popped_value !== wanted.popped_value) begin
            $display("%0t ns: popped_value expected %0d, got %0d",
                     $time, wanted.popped_value, popped_value);
            mismatches++;
         end
         if (status !== wanted.status) begin
            $display("%0t ns: status expected %0d, got %0d",
                     $time, wanted.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   deq_req_if req_chan ();
   deq_rsp_if rsp_chan ();

   double_ended_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   deque_mirror_type mirror;

   int  req_idle_pct;
   int  rsp_idle_pct;
   int  items_sent;
   int  quiet_cycles;
   int  hold_left;
   bit  hold_pending;
   bit  progress;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Sets the idle odds of both sides for one phase of the run.
   task automatic set_phase(int phase);
      case (phase)
         PHASE_QUIET_RX: begin
            req_idle_pct = 36;
            rsp_idle_pct = 84;
         end
         PHASE_QUIET_TX: begin
            req_idle_pct = 84;
            rsp_idle_pct = 36;
         end
         default: begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
      endcase
   endtask

   // Offers one request beat, after a random number of idle cycles, and
   // returns at the falling edge after it was accepted. Valid is left high so
   // that back-to-back beats need no second assignment in one time step.
   task automatic send_request(deq_mode_type mode, deq_word_type value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.push_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic deq_mode_type random_push();
      return $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
   endfunction

   function automatic deq_mode_type random_pop();
      return $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
   endfunction

   // Pushes from both ends until the deque is full and a few pushes are
   // refused, then pops from both ends until it is empty and a few pops are
   // refused. Whatever the starting fill, both limits are reached.
   task automatic fill_and_drain();
      repeat (QUEUE_DEPTH + 3) send_request(random_push(), $urandom);
      repeat (QUEUE_DEPTH + 3) send_request(random_pop(), $urandom);
   endtask

   // Random bursts, each leaning toward pushes, toward pops, or balanced, so
   // that the fill level wanders across the whole range and hits both the
   // full and the empty cases many times.
   task automatic run_bursts(int item_goal);
      int burst_len;
      int push_pct;
      while (items_sent < item_goal) begin
         burst_len = $urandom_range(150, 10);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         repeat (burst_len) begin
            if ($urandom_range(99) < push_pct) send_request(random_push(), $urandom);
            else                               send_request(random_pop(), $urandom);
         end
      end
   endtask

   // Receiver: ready is redrawn at every falling edge, except during a
   // requested hold-off, which this process counts out by itself.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left    = RSP_HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Monitor: every accepted request beat feeds the mirror, every accepted
   // result beat is checked against the oldest expectation. The watchdog
   // counts cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         progress = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            mirror.apply_request(req_chan.mode, req_chan.push_value);
            progress = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            mirror.check_result(rsp_chan.popped_value, rsp_chan.status);
            progress = 1'b1;
         end
         if (progress) quiet_cycles = 0;
         else          quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      mirror              = new();
      items_sent          = 0;
      hold_left           = 0;
      hold_pending        = 1'b0;
      quiet_cycles        = 0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_PUSH_FRONT;
      req_chan.push_value = '0;
      rsp_chan.ready      = 1'b0;
      set_phase(PHASE_QUIET_RX);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Pops on an empty deque come first, then pushes at
      // both ends with the extreme words; the first front push wraps the
      // head index below zero. The deque is then emptied from both ends and
      // popped once more while empty, and pushes after that must work from
      // wherever the head was left.
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_POP_REAR,   $urandom);
      send_request(MODE_PUSH_FRONT, 32'sh8000_0000);
      send_request(MODE_PUSH_REAR,  32'sh7FFF_FFFF);
      send_request(MODE_PUSH_FRONT, 32'sh0000_0000);
      send_request(MODE_PUSH_REAR,  32'shFFFF_FFFF);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_POP_REAR,   $urandom);
      send_request(MODE_POP_REAR,   $urandom);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_PUSH_REAR,  32'sh5555_5555);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(MODE_POP_REAR,   $urandom);
      send_request(MODE_PUSH_FRONT, 32'sh0000_0001);
      send_request(MODE_PUSH_REAR,  32'sh8000_0001);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_POP_FRONT,  $urandom);
      send_request(MODE_POP_REAR,   32'shFFFF_FFFF);

      // The receiver stops for a long stretch while the deque is being
      // filled, so the request side has to stall with valid held high.
      hold_pending = 1'b1;
      fill_and_drain();
      run_bursts(PHASE1_ITEMS);

      set_phase(PHASE_QUIET_TX);
      fill_and_drain();
      run_bursts(PHASE2_ITEMS);

      set_phase(PHASE_NO_IDLE);
      fill_and_drain();
      run_bursts(TOTAL_ITEMS);
      req_chan.valid <= 1'b0;

      // Wait for every outstanding result, then a few more cycles so that a
      // stray extra beat would still be caught by the monitor.
      while (mirror.pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      if (mirror.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
